>>> rtl/stream_find_and_replace_defines.svh
// Assertion helpers for the stream find-and-replace block.
// The asserting module supplies clk and rst.
`ifndef STREAM_FIND_AND_REPLACE_DEFINES_SVH
`define STREAM_FIND_AND_REPLACE_DEFINES_SVH

// Same-cycle implication.
`define SFR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stream_find_and_replace: same-cycle check failed");

// Next-cycle implication.
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stream_find_and_replace: next-cycle check failed");

`endif

>>> rtl/sfr_pkg.sv
`timescale 1ns / 1ps
package sfr_pkg;

  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;
  localparam int LEN_W               = 4;
  localparam int INDEX_W             = 3;
  localparam int CFG_W               = 64;

  typedef logic [LEN_W-1:0] len_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_PATTERN_BYTES      = 3'd0,
    REG_PATTERN_LENGTH     = 3'd1,
    REG_REPLACEMENT_BYTES  = 3'd2,
    REG_REPLACEMENT_LENGTH = 3'd3
  } reg_index_t;

  // Outcome of one input word: how many result words it makes, and
  // whether it closes the text.
  typedef struct packed {
    len_t count;
    logic last;
  } step_t;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> rtl/sfr_window.sv
`timescale 1ns / 1ps
module sfr_window #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  last_in,
  input  logic [63:0]           pattern_bytes,
  input  sfr_pkg::len_t         plen,
  input  logic [63:0]           replacement_bytes,
  input  sfr_pkg::len_t         rlen,
  output sfr_pkg::step_t        info,
  output logic [sfr_pkg::max2(MAX_PATTERN, MAX_REPLACEMENT)-1:0][7:0] result_bytes
);

  localparam int BUF = sfr_pkg::max2(MAX_PATTERN, MAX_REPLACEMENT);

  logic [7:0]    win      [MAX_PATTERN];
  logic [7:0]    wn       [MAX_PATTERN];
  logic [7:0]    wn_shift [MAX_PATTERN];
  sfr_pkg::len_t cnt;
  sfr_pkg::len_t cnt_base;
  sfr_pkg::len_t cnt_inc;
  logic          full;
  logic          match;

  always_comb begin
    cnt_base = (cnt >= plen) ? '0 : cnt;
    cnt_inc  = cnt_base + 1'b1;
    // Drop the new word into the first free slot.
    for (int i = 0; i < MAX_PATTERN; i++) begin
      wn[i] = (sfr_pkg::len_t'(i) == cnt_base) ? data_byte : win[i];
    end
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      wn_shift[i] = wn[i+1];
    end
    wn_shift[MAX_PATTERN-1] = wn[MAX_PATTERN-1];
    full  = (cnt_inc == plen);
    match = full;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((sfr_pkg::len_t'(i) < plen) && (wn[i] != pattern_bytes[i*8 +: 8])) begin
        match = 1'b0;
      end
    end
    for (int i = 0; i < BUF; i++) begin
      result_bytes[i] = match ? replacement_bytes[i*8 +: 8] : 8'h00;
    end
    // On a miss the results are the window itself, oldest first.
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (!match) begin
        result_bytes[i] = wn[i];
      end
    end
    if (match) begin
      info.count = rlen;
    end else if (last_in) begin
      info.count = cnt_inc;
    end else if (full) begin
      info.count = sfr_pkg::len_t'(1);
    end else begin
      info.count = '0;
    end
    info.last = last_in;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cnt <= '0;
    end else if (step) begin
      if (match || last_in) begin
        cnt <= '0;
      end else if (full) begin
        cnt <= cnt_inc - 1'b1;
      end else begin
        cnt <= cnt_inc;
      end
    end
    if (step) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win[i] <= (full && !match) ? wn_shift[i] : wn[i];
      end
    end
  end

endmodule

>>> rtl/stream_find_and_replace.sv
// First result word comes in the cycle after the input word is accepted.
// Throughput: one input word per cycle while each makes at most one result
// and out_ready is high; a word that makes more holds the input until its last
// word is taken from the result shift buffer, one word per ready cycle.
// Reset (rst, synchronous, active high): empties the window and the result
// buffer and restores the configuration registers; no clearing pass.
`timescale 1ns / 1ps
`include "stream_find_and_replace_defines.svh"
module stream_find_and_replace #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sfr_pkg::INDEX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  data_byte,
  input  logic                        last_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        has_byte,
  output logic                        out_last
);

  localparam int BUF = sfr_pkg::max2(MAX_PATTERN, MAX_REPLACEMENT);

  logic [63:0]    pattern_bytes;
  sfr_pkg::len_t  pattern_length;
  logic [63:0]    replacement_bytes;
  sfr_pkg::len_t  replacement_length;
  sfr_pkg::len_t  plen;
  sfr_pkg::len_t  rlen;
  logic           pattern_clear;

  sfr_pkg::step_t         info;
  logic [BUF-1:0][7:0]    result_bytes;
  logic [BUF-1:0][7:0]    obuf;
  sfr_pkg::len_t          rem;
  logic                   marker;
  logic                   last_flag;
  logic                   accept;
  logic                   load;
  logic                   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= sfr_pkg::len_t'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_we) begin
      unique case (sfr_pkg::reg_index_t'(cfg_index))
        sfr_pkg::REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        sfr_pkg::REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[3:0];
        sfr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        sfr_pkg::REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign pattern_clear = cfg_we &&
                         (cfg_index == sfr_pkg::INDEX_W'(sfr_pkg::REG_PATTERN_LENGTH));

  // Clamp lengths: zero pattern acts as one, oversize acts as the maximum.
  always_comb begin
    if (pattern_length == '0) begin
      plen = sfr_pkg::len_t'(1);
    end else if (pattern_length > sfr_pkg::len_t'(MAX_PATTERN)) begin
      plen = sfr_pkg::len_t'(MAX_PATTERN);
    end else begin
      plen = pattern_length;
    end
    if (replacement_length > sfr_pkg::len_t'(MAX_REPLACEMENT)) begin
      rlen = sfr_pkg::len_t'(MAX_REPLACEMENT);
    end else begin
      rlen = replacement_length;
    end
  end

  assign in_ready = (rem == '0) || ((rem == sfr_pkg::len_t'(1)) && out_ready);
  assign accept   = in_valid && in_ready;
  assign load     = accept && ((info.count != '0) || info.last);
  assign pop      = out_valid && out_ready;

  sfr_window #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_window (
    .clk               (clk),
    .rst               (rst),
    .clear             (pattern_clear),
    .step              (accept),
    .data_byte         (data_byte),
    .last_in           (last_in),
    .pattern_bytes     (pattern_bytes),
    .plen              (plen),
    .replacement_bytes (replacement_bytes),
    .rlen              (rlen),
    .info              (info),
    .result_bytes      (result_bytes)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= (info.count == '0) ? sfr_pkg::len_t'(1) : info.count;
    end else if (pop) begin
      rem <= rem - 1'b1;
    end
    if (load) begin
      obuf      <= result_bytes;
      marker    <= (info.count == '0);
      last_flag <= info.last;
    end else if (pop) begin
      // Advance to the next queued word.
      for (int i = 0; i < BUF - 1; i++) begin
        obuf[i] <= obuf[i+1];
      end
    end
  end

  assign out_valid = (rem != '0);
  assign out_byte  = marker ? 8'h00 : obuf[0];
  assign has_byte  = !marker;
  assign out_last  = last_flag && (rem == sfr_pkg::len_t'(1));

  `SFR_ASSERT_IMPLY(a_hold_input, rem > sfr_pkg::len_t'(1), !in_ready)
  `SFR_ASSERT_IMPLY(a_rem_bound, 1'b1, rem <= sfr_pkg::len_t'(BUF))
  `SFR_ASSERT_NEXT(a_last_gives_word, accept && last_in, out_valid)
  `SFR_ASSERT_IMPLY(a_marker_is_last, out_valid && !has_byte, out_last)

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int LIMIT       = 300000;
  localparam int PHASE_WORDS = 43;
  localparam int IDLE_PCT    = 18;
  localparam int HOLD_CYCLES = 120;
  localparam logic [sfr_pkg::INDEX_W-1:0] REG_UNUSED = 3'd6;

  // Pattern and replacement length register values per random phase, phase 0 lowest.
  localparam logic [39:0] PLEN_SET = {4'd6, 4'd4, 4'd8, 4'd5, 4'd2,
                                      4'd15, 4'd0, 4'd3, 4'd8, 4'd1};
  localparam logic [39:0] RLEN_SET = {4'd4, 4'd5, 4'd8, 4'd3, 4'd0,
                                      4'd1, 4'd15, 4'd2, 4'd8, 4'd0};

  typedef struct {
    logic [7:0] b;
    logic       has;
    logic       last;
  } text_word_t;

  class replace_scoreboard;
    logic [63:0] pat_bytes;
    logic [63:0] rep_bytes;
    logic [3:0]  pat_len_reg;
    logic [3:0]  rep_len_reg;
    logic [7:0]  window [8];
    int unsigned held;
    text_word_t  pending_q [$];
    int          mismatches;

    function new();
      pat_bytes   = '0;
      rep_bytes   = '0;
      pat_len_reg = 4'd1;
      rep_len_reg = 4'd0;
      held        = 0;
      mismatches  = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function int unsigned pat_len();
      if (pat_len_reg == 0) return 1;
      if (pat_len_reg > sfr_pkg::MAX_PATTERN_DEF) return sfr_pkg::MAX_PATTERN_DEF;
      return pat_len_reg;
    endfunction

    function void note_config(logic [sfr_pkg::INDEX_W-1:0] idx, logic [63:0] v);
      case (idx)
        sfr_pkg::REG_PATTERN_BYTES: pat_bytes = v;
        sfr_pkg::REG_PATTERN_LENGTH: begin
          // a new length drops whatever the window holds
          pat_len_reg = v[3:0];
          held = 0;
        end
        sfr_pkg::REG_REPLACEMENT_BYTES: rep_bytes = v;
        sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len_reg = v[3:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [7:0] b, logic last);
      text_word_t  step_out [16];
      int          k;
      int unsigned plen;
      int unsigned rlen;
      logic        hit;
      plen = pat_len();
      rlen = (rep_len_reg > sfr_pkg::MAX_REPLACEMENT_DEF) ?
             sfr_pkg::MAX_REPLACEMENT_DEF : rep_len_reg;
      k = 0;
      if (held >= plen) held = 0;
      window[held] = b;
      held++;
      if (held == plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++)
          if (window[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          for (int i = 0; i < rlen; i++) begin
            step_out[k] = '{rep_bytes[8*i +: 8], 1'b1, 1'b0};
            k++;
          end
          held = 0;
        end else begin
          // emit the oldest byte, slide the rest down
          step_out[k] = '{window[0], 1'b1, 1'b0};
          k++;
          for (int i = 0; i < 7; i++) window[i] = window[i+1];
          held--;
        end
      end
      if (last) begin
        for (int i = 0; i < held; i++) begin
          step_out[k] = '{window[i], 1'b1, 1'b0};
          k++;
        end
        held = 0;
        if (k == 0) begin
          step_out[0] = '{8'h00, 1'b0, 1'b1};
          k = 1;
        end else begin
          step_out[k-1].last = 1'b1;
        end
      end
      for (int i = 0; i < k; i++) pending_q.insert(pending_q.size(), step_out[i]);
    endfunction

    function void check_result(logic [7:0] b, logic has, logic last);
      text_word_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: byte %h has_byte %b last %b", b, has, last);
        return;
      end
      want = pending_q.pop_front();
      if (want.b !== b || want.has !== has || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected byte %h has_byte %b last %b, %s %h %s %b %s %b",
                   want.b, want.has, want.last, "got byte", b, "has_byte", has,
                   "last", last);
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_we;
  logic [sfr_pkg::INDEX_W-1:0] cfg_index;
  logic [sfr_pkg::CFG_W-1:0]   cfg_data;
  logic                        in_valid;
  logic                        in_ready;
  logic [7:0]                  data_byte;
  logic                        last_in;
  logic                        out_valid;
  logic                        out_ready;
  logic [7:0]                  out_byte;
  logic                        has_byte;
  logic                        out_last;

  replace_scoreboard sb;
  bit                no_idle  = 1'b0;
  bit                hold_req = 1'b0;
  int                cycles;

  stream_find_and_replace dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Output side: check every accepted word, stall at random or on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(out_byte, has_byte, out_last);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_in   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(b, last);
  endtask

  // Drop valid, drain all expected words, then let the block idle before returning.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sfr_pkg::INDEX_W-1:0] idx, input logic [63:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.note_config(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] pat, input logic [3:0] plen,
                            input logic [63:0] rep, input logic [3:0] rlen);
    write_reg(sfr_pkg::REG_PATTERN_BYTES, pat);
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, {60'd0, plen});
    write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, rep);
    write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, {60'd0, rlen});
  endtask

  initial begin
    logic [63:0] pat;
    logic [63:0] rep;
    logic [7:0]  b;
    int          words;
    int          plen;
    int          cut;
    int          r;
    int          idx;
    sb = new();
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    data_byte <= '0;
    last_in   <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: pattern is one zero byte, matches are deleted.
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h00, 1'b1);   // whole step deleted: empty end word
    settle();
    write_reg(REG_UNUSED, '1);

    set_config(64'h6261, 4'd2, 64'h5a5958, 4'd3);
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h63, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h78, 1'b1);
    send_word(8'h61, 1'b0);
    settle();
    write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd2);   // held byte is lost
    send_word(8'h62, 1'b1);
    settle();

    // Zero pattern length acts as one, oversized replacement as eight.
    set_config('1, 4'd0, '1, 4'd15);
    send_word(8'hff, 1'b0);
    send_word(8'h00, 1'b1);
    settle();

    // Oversized pattern length acts as eight.
    set_config('1, 4'd15, '0, 4'd8);
    repeat (8) send_word(8'hff, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h00, 1'b1);

    for (int p = 0; p < 10; p++) begin
      settle();
      pat = {$urandom, $urandom};
      if (p == 2) pat = '0;
      if (p == 7) pat = '1;
      rep = {$urandom, $urandom};
      set_config(pat, PLEN_SET[4*p +: 4], rep, RLEN_SET[4*p +: 4]);
      no_idle = (p == 5);
      if (p == 3) hold_req = 1'b1;
      plen = sb.pat_len();
      words = 0;
      while (words < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        if (r < 50) cut = plen;
        else if (r < 70) cut = (plen > 1) ? $urandom_range(1, plen - 1) : 1;
        else cut = 0;
        if (cut > 0) begin
          // whole pattern or a broken prefix of it
          for (int i = 0; i < cut && words < PHASE_WORDS; i++) begin
            send_word(pat[8*i +: 8], $urandom_range(0, 11) == 0);
            words++;
          end
        end else begin
          idx = $urandom_range(0, plen - 1);
          b = (r < 85) ? pat[8*idx +: 8] : 8'($urandom_range(0, 255));
          send_word(b, $urandom_range(0, 11) == 0);
          words++;
        end
      end
    end
    no_idle = 1'b0;

    settle();
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> stream_find_and_replace.f
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_window.sv
rtl/stream_find_and_replace.sv
verif/tb_top.sv
